// ===== rtl/xed_pkg.sv =====
// Shared types, constants and the entity-name lookup for the XML entity decoder.
// Used by every module under rtl; depends on nothing else.
package xed_pkg;

  // Longest span from an '&' to its ';', counted in characters.
  localparam int MAX_SPAN   = 10;
  localparam int NAME_DEPTH = MAX_SPAN - 1;
  localparam int JOB_LEN    = MAX_SPAN + 1;

  // Widths of counters and indexes derived from the span.
  localparam int NCW = $clog2(NAME_DEPTH + 1);
  localparam int NIW = $clog2(NAME_DEPTH);
  localparam int JCW = $clog2(JOB_LEN + 1);
  localparam int JIW = $clog2(JOB_LEN);
  localparam int APW = $clog2(MAX_SPAN + 1);

  // Job queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic [7:0] byte_t;
  typedef byte_t [NAME_DEPTH-1:0] name_t;

  localparam byte_t AMP  = 8'h26;
  localparam byte_t SEMI = 8'h3b;

  // One job: the output bytes caused by one input character.
  typedef struct packed {
    byte_t [JOB_LEN-1:0] data;
    logic [JCW-1:0]      len;
    logic                last;
  } job_t;

  typedef struct packed {
    logic  hit;
    byte_t ch;
  } lookup_t;

  // Known entity names, right-justified in 48 bits; first character is most significant.
  localparam int ENT_NUM    = 12;
  localparam int ENT_MAXLEN = 6;
  localparam logic [8*ENT_MAXLEN-1:0] ENT_TEXT [ENT_NUM] = '{
    "amp", "lt", "gt", "quot", "apos", "#39",
    "#x27", "#8217", "#x2019", "#160", "#xa0", "nbsp"
  };
  localparam int ENT_LEN [ENT_NUM] = '{3, 2, 2, 4, 4, 3, 4, 5, 6, 4, 4, 4};
  localparam byte_t ENT_CHAR [ENT_NUM] = '{
    8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h27,
    8'h27, 8'h27, 8'h27, 8'h20, 8'h20, 8'h20
  };

  // Match the held name against the entity table.
  function automatic lookup_t lookup_name(name_t nm, logic [NCW-1:0] cnt);
    lookup_t r;
    logic    ok;
    r = '0;
    for (int k = 0; k < ENT_NUM; k++) begin
      ok = (int'(cnt) == ENT_LEN[k]);
      for (int j = 0; j < ENT_MAXLEN; j++) begin
        if (j < ENT_LEN[k]) begin
          if (j >= NAME_DEPTH) begin
            ok = 1'b0;
          end else if (nm[j] != ENT_TEXT[k][(ENT_LEN[k] - 1 - j) * 8 +: 8]) begin
            ok = 1'b0;
          end
        end
      end
      if (ok) begin
        r.hit = 1'b1;
        r.ch  = ENT_CHAR[k];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/xed_front.sv =====
// Front part: accepts characters, tracks the pending entity name and builds output jobs.
// Depends on xed_pkg.
module xed_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  xed_pkg::byte_t in_byte,
  input  logic           in_last,
  input  logic           q_full,
  output logic           q_push,
  output xed_pkg::job_t  q_job
);
  import xed_pkg::*;

  logic           pend, pend_next;
  logic [NCW-1:0] cnt, cnt_next;
  name_t          name, name_next;

  logic                 accept;
  lookup_t              hit;
  byte_t [MAX_SPAN-1:0] tmp;
  byte_t [MAX_SPAN:1]   fill;
  logic [APW-1:0]       amp_pos;
  logic                 amp_found;
  job_t                 job;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign hit    = lookup_name(name, cnt);

  // Held name plus the new character, and the first '&' among them.
  always_comb begin
    for (int i = 0; i < MAX_SPAN; i++) begin
      tmp[i] = (i < NAME_DEPTH) ? name[i] : in_byte;
    end
    amp_pos = APW'(MAX_SPAN);
    for (int i = MAX_SPAN - 1; i >= 0; i--) begin
      if (tmp[i] == AMP) begin
        amp_pos = APW'(i);
      end
    end
    amp_found = (amp_pos != APW'(MAX_SPAN));
  end

  // Verbatim output after the '&': held name bytes, then the new character.
  always_comb begin
    for (int k = 1; k <= MAX_SPAN; k++) begin
      if ((k - 1) < NAME_DEPTH && NCW'(k - 1) != cnt) begin
        fill[k] = name[k-1];
      end else begin
        fill[k] = in_byte;
      end
    end
  end

  // Classify the character and work out the job and the next state.
  always_comb begin
    job       = '0;
    job.last  = in_last;
    pend_next = pend;
    cnt_next  = cnt;
    name_next = name;
    if (!pend) begin
      if (in_byte == AMP) begin
        pend_next = 1'b1;
        cnt_next  = '0;
        if (in_last) begin
          job.data[0] = AMP;
          job.len     = JCW'(1);
        end
      end else begin
        job.data[0] = in_byte;
        job.len     = JCW'(1);
      end
    end else if (in_byte == SEMI || cnt < NCW'(NAME_DEPTH)) begin
      if (in_byte == SEMI && hit.hit) begin
        job.data[0] = hit.ch;
        job.len     = JCW'(1);
      end else if (in_byte == SEMI || in_last) begin
        job.data[0] = AMP;
        for (int k = 1; k <= MAX_SPAN; k++) begin
          job.data[k] = fill[k];
        end
        job.len = JCW'(int'(cnt) + 2);
      end
      if (in_byte == SEMI) begin
        pend_next = 1'b0;
        cnt_next  = '0;
      end else begin
        name_next[cnt[NIW-1:0]] = in_byte;
        cnt_next                = cnt + NCW'(1);
      end
    end else begin
      // Span exceeded: emit the '&' and rescan the held bytes for a new one.
      job.data[0] = AMP;
      for (int k = 1; k <= MAX_SPAN; k++) begin
        job.data[k] = tmp[k-1];
      end
      if (amp_found && !in_last) begin
        job.len   = JCW'(int'(amp_pos) + 1);
        pend_next = 1'b1;
        cnt_next  = NCW'(MAX_SPAN - 1 - int'(amp_pos));
        for (int j = 0; j < NAME_DEPTH; j++) begin
          for (int i = 0; i < MAX_SPAN; i++) begin
            if (i == int'(amp_pos) + 1 + j) begin
              name_next[j] = tmp[i];
            end
          end
        end
      end else begin
        job.len   = JCW'(JOB_LEN);
        pend_next = 1'b0;
        cnt_next  = '0;
      end
    end
    if (in_last) begin
      pend_next = 1'b0;
      cnt_next  = '0;
    end
  end

  assign q_push = accept && (job.len != '0);
  assign q_job  = job;

  // Entity state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      pend <= pend_next;
      cnt  <= cnt_next;
    end
  end

  // Name bytes carry no reset; only entries below the count are read.
  always_ff @(posedge clk) begin
    if (accept) begin
      name <= name_next;
    end
  end

endmodule

// ===== rtl/xed_queue.sv =====
// Short job queue that decouples the front part from the back part.
// Depends on xed_pkg.
module xed_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_push,
  input  xed_pkg::job_t q_in,
  output logic          q_full,
  output logic          q_valid,
  output xed_pkg::job_t q_out,
  input  logic          q_pop
);
  import xed_pkg::*;

  job_t           slots [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign q_full  = (count == QCW'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_out   = slots[rd_ptr];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && q_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCW'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_in;
    end
  end

endmodule

// ===== rtl/xed_back.sv =====
// Back part: walks the bytes of the head job into the output register.
// Depends on xed_pkg.
module xed_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  xed_pkg::job_t  q_job,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output xed_pkg::byte_t out_byte,
  output logic           out_last
);
  import xed_pkg::*;

  logic [JIW-1:0] idx;
  logic           ovalid;
  byte_t          obyte;
  logic           olast;
  logic           load;
  logic           last_slot;

  assign load      = q_valid && (!ovalid || pop);
  assign last_slot = (JCW'(idx) == q_job.len - JCW'(1));
  assign q_pop     = load && last_slot;

  assign empty    = !ovalid;
  assign out_byte = obyte;
  assign out_last = olast;

  // Output register valid and the byte index within the head job.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      ovalid <= 1'b1;
      idx    <= last_slot ? '0 : idx + JIW'(1);
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      obyte <= q_job.data[idx];
      olast <= q_job.last && last_slot;
    end
  end

endmodule

// ===== rtl/xml_entity_decoder.sv =====
// Top level of the streaming XML entity decoder.
// Depends on xed_pkg, xed_front, xed_queue and xed_back.
//
// Usage:
// Characters enter through push/full with in_byte and in_last; in_last marks the
// final character of a string. Decoded characters leave through empty/pop with
// out_byte and out_last; out_last is set on the final output character of a string.
// Each accepted character becomes a job of 0 to 11 output characters. Jobs wait in a
// two-entry queue and the back part delivers one output character per cycle while the
// receiver holds pop high. An accepted character passes through the job queue and then
// the output register on its way to the output ports.
// Throughput: one character per cycle while jobs have one output character and pop is
// held high. The single output register takes the characters of a longer job one at a
// time, and full rises once the job queue holds two jobs.
// Reset (rst, synchronous) clears the queue, the output register and any pending
// entity. When the receiver holds pop low, the current result stays on the ports,
// the queue fills and full holds off further input.
module xml_entity_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  xed_pkg::byte_t in_byte,
  input  logic           in_last,
  output logic           empty,
  input  logic           pop,
  output xed_pkg::byte_t out_byte,
  output logic           out_last
);
  import xed_pkg::*;

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t q_in;
  job_t q_out;

  // Front part: classification and job building.
  xed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_in)
  );

  // Job queue between the two parts.
  xed_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_in    (q_in),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_out   (q_out),
    .q_pop   (q_pop)
  );

  // Back part: output serialization.
  xed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (q_out),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  // The output register is empty after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // Every queued job carries between one and the maximum number of characters.
  a_job_len: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_in.len != '0 && q_in.len <= JCW'(JOB_LEN)))
    else $error("job with bad length pushed");

  // The back part retires a job only when one is queued.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job retired from an empty queue");

endmodule

// ===== tb/xed_scoreboard_pkg.sv =====
// Scoreboard for the XML entity decoder testbench: predicts the decoded characters
// and checks each one the block delivers. Depends on xed_pkg for types and constants.
package xed_scoreboard_pkg;

  import xed_pkg::*;

  class decode_scoreboard;

    typedef struct packed {
      byte_t ch;
      logic  last;
    } out_char_t;

    // Decoded characters still owed by the block, oldest first.
    out_char_t expected_chars[$];
    // Characters caused by the input being predicted.
    byte_t step_chars[$];

    // Predictor state: the open entity and the name bytes held for it.
    byte_t       held_name[NAME_DEPTH];
    int unsigned held_count;
    bit          amp_open;

    int unsigned errors;

    function new();
      held_count = 0;
      amp_open   = 1'b0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    // Returns the character a known entity name stands for, or -1.
    function int entity_char();
      logic [47:0] key;
      key = '0;
      if (held_count == 0 || held_count > 6) return -1;
      for (int j = 0; j < held_count; j++) key = {key[39:0], held_name[j]};
      case (held_count)
        2: begin
          if (key == "lt") return 8'h3c;
          if (key == "gt") return 8'h3e;
        end
        3: begin
          if (key == "amp") return 8'h26;
          if (key == "#39") return 8'h27;
        end
        4: begin
          if (key == "quot") return 8'h22;
          if (key == "apos" || key == "#x27") return 8'h27;
          if (key == "#160" || key == "#xa0" || key == "nbsp") return 8'h20;
        end
        5: begin
          if (key == "#8217") return 8'h27;
        end
        6: begin
          if (key == "#x2019") return 8'h27;
        end
        default: ;
      endcase
      return -1;
    endfunction

    // Span exceeded: scan the held bytes and the newest one for a fresh '&'.
    function void rescan(byte_t newest);
      byte_t scan[$];
      scan.delete();
      for (int i = 0; i < held_count; i++) scan = {scan, held_name[i]};
      scan = {scan, newest};
      amp_open   = 1'b0;
      held_count = 0;
      foreach (scan[i]) begin
        if (!amp_open) begin
          if (scan[i] == AMP) amp_open = 1'b1;
          else step_chars = {step_chars, scan[i]};
        end else if (held_count < NAME_DEPTH) begin
          held_name[held_count] = scan[i];
          held_count++;
        end
      end
    endfunction

    // Notes one accepted input transaction and queues the characters it causes.
    function void predict_char(byte_t ch, logic last);
      int        decoded;
      out_char_t item;
      step_chars.delete();
      if (!amp_open) begin
        if (ch == AMP) begin
          amp_open   = 1'b1;
          held_count = 0;
        end else begin
          step_chars = {step_chars, ch};
        end
      end else if (ch == SEMI) begin
        decoded = entity_char();
        if (decoded >= 0) begin
          step_chars = {step_chars, byte_t'(decoded)};
        end else begin
          // Unknown name goes out verbatim with its delimiters.
          step_chars = {step_chars, AMP};
          for (int i = 0; i < held_count; i++) step_chars = {step_chars, held_name[i]};
          step_chars = {step_chars, SEMI};
        end
        amp_open   = 1'b0;
        held_count = 0;
      end else if (held_count < NAME_DEPTH) begin
        held_name[held_count] = ch;
        held_count++;
      end else begin
        step_chars = {step_chars, AMP};
        rescan(ch);
      end

      // End of string flushes whatever entity is still open.
      if (last) begin
        if (amp_open) begin
          step_chars = {step_chars, AMP};
          for (int i = 0; i < held_count; i++) step_chars = {step_chars, held_name[i]};
        end
        amp_open   = 1'b0;
        held_count = 0;
      end

      foreach (step_chars[i]) begin
        item.ch   = step_chars[i];
        item.last = last && (i == step_chars.size() - 1);
        expected_chars = {expected_chars, item};
      end
    endfunction

    // Checks one accepted output transaction against the oldest expectation.
    function void check_char(byte_t ch, logic last);
      out_char_t want;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected output: byte %02h last %0b", ch, last);
        end
        return;
      end
      want = expected_chars.pop_front();
      if (want.ch !== ch || want.last !== last) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   want.ch, want.last, ch, last);
        end
      end
    endfunction

  endclass

endpackage

// ===== tb/tb_xml_entity_decoder.sv =====
// Top-level testbench for xml_entity_decoder: drives strings of directed and random
// characters and checks every decoded character. Depends on xed_pkg and xed_scoreboard_pkg.
module tb_xml_entity_decoder;

  timeunit 1ns;
  timeprecision 1ps;

  import xed_pkg::*;
  import xed_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int LONG_HOLD    = 250;
  localparam int QUIET_LIMIT  = 3000;
  localparam int CALM_ITEMS   = 60;

  typedef struct {
    byte_t ch;
    bit    last;
  } char_item_t;

  logic  clk;
  logic  rst     = 1'b1;
  logic  push    = 1'b0;
  byte_t in_byte = '0;
  logic  in_last = 1'b0;
  logic  pop     = 1'b0;
  logic  full;
  logic  empty;
  byte_t out_byte;
  logic  out_last;

  decode_scoreboard sb = new();

  char_item_t char_plan[$];
  string known_names[12] = '{"amp", "lt", "gt", "quot", "apos", "#39",
                             "#x27", "#8217", "#x2019", "#160", "#xa0", "nbsp"};

  bit hold_request = 1'b0;
  bit results_held = 1'b0;
  bit calm         = 1'b0;
  int quiet_cycles = 0;

  xml_entity_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Appends one character to the stimulus plan.
  function automatic void add_char(byte_t c);
    char_item_t item;
    item.ch   = c;
    item.last = 1'b0;
    char_plan = {char_plan, item};
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(byte_t'(s[i]));
  endfunction

  function automatic void end_string();
    char_plan[char_plan.size() - 1].last = 1'b1;
  endfunction

  // A name byte: often a character that appears in entity names or an '&', else any value but ';'.
  function automatic byte_t name_byte();
    string alphabet;
    byte_t c;
    alphabet = "#x0123789abglmnopqstu&";
    if ($urandom_range(0, 1) == 0) return byte_t'(alphabet[$urandom_range(0, alphabet.len() - 1)]);
    do c = byte_t'($urandom_range(0, 255)); while (c == SEMI);
    return c;
  endfunction

  // One random string built from entity-shaped segments and some noise.
  function automatic void plan_random_string();
    string nm;
    int    pos;
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          add_char(AMP);
          add_text(known_names[$urandom_range(0, 11)]);
          add_char(SEMI);
        end
        4: begin
          // Unknown name, from empty up to the longest that still fits the span.
          add_char(AMP);
          repeat ($urandom_range(0, NAME_DEPTH)) add_char(name_byte());
          add_char(SEMI);
        end
        5: begin
          // Name that runs past the span.
          add_char(AMP);
          repeat ($urandom_range(NAME_DEPTH + 1, NAME_DEPTH + 5)) add_char(name_byte());
        end
        6: add_char(SEMI);
        7: begin
          // Known name with one letter changed, sometimes left without its ';'.
          nm  = known_names[$urandom_range(0, 11)];
          pos = $urandom_range(0, nm.len() - 1);
          nm[pos] = byte'(8'h61 + $urandom_range(0, 25));
          add_char(AMP);
          add_text(nm);
          if ($urandom_range(0, 1) == 0) add_char(SEMI);
        end
        8: begin
          // Entity still open when the segment ends.
          add_char(AMP);
          repeat ($urandom_range(0, 4)) add_char(name_byte());
        end
        default: begin
          repeat ($urandom_range(1, 4)) add_char(byte_t'($urandom_range(0, 255)));
        end
      endcase
    end
    end_string();
  endfunction

  // Offers one character and waits until the block takes it.
  task automatic send_char(char_item_t item);
    push    <= 1'b1;
    in_byte <= item.ch;
    in_last <= item.last;
    do @(posedge clk); while (full);
  endtask

  // Watchdog and transaction monitor.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (push && !full) sb.predict_char(in_byte, in_last);
      if (pop && !empty) sb.check_char(out_byte, out_last);
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold when asked, none near the end.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        results_held = 1'b1;
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        results_held = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Sender and end of run.
  initial begin
    int directed_items;
    int hold_at;
    int drain_at;

    // Directed strings: extreme bytes, lone ';', a known entity, an empty name.
    add_char(8'h00);
    add_char(8'hff);
    add_char(SEMI);
    add_text("&amp;");
    add_text("&;");
    end_string();
    // Nested '&' that takes over once the span runs out, then a flush at end of string.
    add_text("&a&bcdefghij");
    end_string();
    directed_items = char_plan.size();

    while (char_plan.size() < directed_items + RANDOM_ITEMS) plan_random_string();
    hold_at  = char_plan.size() / 3;
    drain_at = char_plan.size() / 2;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < char_plan.size(); i++) begin
      if (i >= char_plan.size() - CALM_ITEMS) calm = 1'b1;
      if (i == hold_at) hold_request = 1'b1;
      if (i == drain_at) begin
        // Pause until the block has delivered everything owed so far.
        push <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end else if (!calm && !results_held && !hold_request && $urandom_range(0, 5) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      send_char(char_plan[i]);
    end
    push <= 1'b0;

    // Drain, then keep watching the output for any stray character.
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
